### rtl/software_timer_pool_core_defines.svh
// Assertion helpers, clocked on clk_i and disabled in reset.
`ifndef SOFTWARE_TIMER_POOL_CORE_DEFINES_SVH
`define SOFTWARE_TIMER_POOL_CORE_DEFINES_SVH

// same-cycle implication
`define STP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stp assertion failed");

// next-cycle implication
`define STP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stp assertion failed");

`endif

### rtl/stp_pkg.sv
`default_nettype none
package stp_pkg;

  localparam int unsigned TimersDefault = 16;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned CntW          = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    OpSet   = 2'd0,
    OpUnset = 2'd1,
    OpTick  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KindSetDone   = 3'd0,
    KindSetFull   = 3'd1,
    KindUnsetDone = 3'd2,
    KindFired     = 3'd3,
    KindTickQuiet = 3'd4
  } kind_e;

  typedef struct packed {
    logic [15:0] event_id;
    logic [30:0] reload;
    logic [31:0] remaining;
    logic        rpt;
    logic        report;
  } slot_t;

  typedef struct packed {
    logic capture;
    logic idx_inc;
    logic set_try;
    logic mem_rd;
    logic eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic dt_zero;
    logic idx_last;
    logic slot_free;
    logic eval_stall;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/stp_if.sv
`default_nettype none
interface stp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] event_id;
  logic [30:0] duration;
  logic        periodic;
  logic        report_enable;
  logic [30:0] elapsed;

  modport source (output valid, opcode, event_id, duration, periodic, report_enable, elapsed,
                  input ready);
  modport sink (input valid, opcode, event_id, duration, periodic, report_enable, elapsed,
                output ready);
endinterface

interface stp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] fired_event;
  logic        last;

  modport source (output valid, kind, fired_event, last, input ready);
  modport sink (input valid, kind, fired_event, last, output ready);
endinterface
`default_nettype wire

### rtl/stp_datapath.sv
`default_nettype none
module stp_datapath #(
  parameter int unsigned TIMERS = stp_pkg::TimersDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire stp_pkg::cmd_t cmd_i,
  output stp_pkg::sts_t      sts_o,
  input  wire logic [1:0]    in_opcode_i,
  input  wire logic [15:0]   in_event_id_i,
  input  wire logic [30:0]   in_duration_i,
  input  wire logic          in_periodic_i,
  input  wire logic          in_report_enable_i,
  input  wire logic [30:0]   in_elapsed_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [2:0]         out_kind_o,
  output logic [15:0]        out_fired_event_o,
  output logic               out_last_o
);

  localparam int unsigned IdxW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  stp_pkg::op_e   op_q;
  logic [15:0]    ev_q;
  logic [30:0]    dur_q;
  logic           per_q;
  logic           rep_q;
  logic [30:0]    dt_q;

  logic [IdxW-1:0]          idx_q;
  logic [TIMERS-1:0]        active_q;
  logic                     set_ok_q;
  logic                     pend_q;
  logic [15:0]              pend_ev_q;
  logic [stp_pkg::CntW-1:0] cnt_q;

  stp_pkg::slot_t mem_q [TIMERS];
  stp_pkg::slot_t rd_q;
  stp_pkg::slot_t wdata;
  logic           mem_we;

  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [15:0] out_ev_q;
  logic        out_last_q;

  logic        act;
  logic [32:0] diff;
  logic        fire;
  logic        rep_fire;
  logic        out_free;
  logic        push;
  logic [2:0]  push_kind;
  logic [15:0] push_ev;
  logic        push_last;
  logic        clr_act;
  logic        set_act;

  assign act      = active_q[idx_q];
  assign diff     = {rd_q.remaining[31], rd_q.remaining} - {2'b00, dt_q};
  assign fire     = act && (diff[32] || (diff == '0));
  assign rep_fire = (op_q == stp_pkg::OpTick) && fire && rd_q.report &&
                    (cnt_q < stp_pkg::CntW'(stp_pkg::MaxResults));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mem_we  = 1'b0;
    wdata   = rd_q;
    clr_act = 1'b0;
    set_act = 1'b0;
    if (cmd_i.set_try && !act) begin
      mem_we  = 1'b1;
      set_act = 1'b1;
      wdata   = '{event_id: ev_q, reload: dur_q, remaining: {1'b0, dur_q},
                  rpt: per_q, report: rep_q};
    end else if (cmd_i.eval && act) begin
      if (op_q == stp_pkg::OpUnset) begin
        clr_act = (rd_q.event_id == ev_q);
      end else if (op_q == stp_pkg::OpTick) begin
        if (!fire) begin
          mem_we          = 1'b1;
          wdata.remaining = diff[31:0];
        end else if (rd_q.rpt) begin
          mem_we          = 1'b1;
          wdata.remaining = {1'b0, rd_q.reload};
        end else begin
          clr_act = 1'b1;
        end
      end
    end
  end

  always_comb begin
    push      = 1'b0;
    push_kind = stp_pkg::KindFired;
    push_ev   = pend_ev_q;
    push_last = 1'b0;
    if (cmd_i.eval && rep_fire && pend_q) begin
      push = 1'b1;
    end else if (cmd_i.finish) begin
      push      = 1'b1;
      push_last = 1'b1;
      push_ev   = '0;
      case (op_q)
        stp_pkg::OpSet:   push_kind = set_ok_q ? stp_pkg::KindSetDone : stp_pkg::KindSetFull;
        stp_pkg::OpUnset: push_kind = stp_pkg::KindUnsetDone;
        default: begin
          if (pend_q) begin
            push_kind = stp_pkg::KindFired;
            push_ev   = pend_ev_q;
          end else begin
            push_kind = stp_pkg::KindTickQuiet;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= stp_pkg::op_e'(in_opcode_i);
      ev_q  <= in_event_id_i;
      dur_q <= in_duration_i;
      per_q <= in_periodic_i;
      rep_q <= in_report_enable_i;
      dt_q  <= in_elapsed_i;
    end
    if (mem_we) mem_q[idx_q] <= wdata;
    if (cmd_i.mem_rd) rd_q <= mem_q[idx_q];
    if (cmd_i.eval && rep_fire) pend_ev_q <= rd_q.event_id;
    if (push) begin
      out_kind_q <= push_kind;
      out_ev_q   <= push_ev;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      active_q    <= '0;
      set_ok_q    <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_q    <= '0;
        set_ok_q <= 1'b0;
        pend_q   <= 1'b0;
        cnt_q    <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (set_act) begin
        active_q[idx_q] <= 1'b1;
        set_ok_q        <= 1'b1;
      end
      if (clr_act) active_q[idx_q] <= 1'b0;
      if (cmd_i.eval && rep_fire) begin
        pend_q <= 1'b1;
        cnt_q  <= cnt_q + 1'b1;
      end
      if (cmd_i.finish) pend_q <= 1'b0;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.dt_zero    = (dt_q == '0);
  assign sts_o.idx_last   = (idx_q == IdxW'(TIMERS - 1));
  assign sts_o.slot_free  = !act;
  assign sts_o.eval_stall = rep_fire && pend_q && !out_free;
  assign sts_o.out_free   = out_free;

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_fired_event_o = out_ev_q;
  assign out_last_o        = out_last_q;

endmodule
`default_nettype wire

### rtl/stp_ctrl.sv
`default_nettype none
module stp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire stp_pkg::sts_t sts_i,
  output stp_pkg::cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDecode = 6'b000010,
    StSet    = 6'b000100,
    StRead   = 6'b001000,
    StEval   = 6'b010000,
    StFinish = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        case (sts_i.op)
          stp_pkg::OpSet:   state_d = StSet;
          stp_pkg::OpUnset: state_d = StRead;
          stp_pkg::OpTick:  state_d = sts_i.dt_zero ? StFinish : StRead;
          default:          state_d = StIdle;
        endcase
      end
      StSet: begin
        cmd_o.set_try = 1'b1;
        if (sts_i.slot_free || sts_i.idx_last) begin
          state_d = StFinish;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      StRead: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = StEval;
      end
      StEval: begin
        if (!sts_i.eval_stall) begin
          cmd_o.eval = 1'b1;
          if (sts_i.idx_last) begin
            state_d = StFinish;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = StRead;
          end
        end
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/software_timer_pool_core.sv
// Pool of TIMERS countdown slots.
// in_i carries one command word: set (opcode 0), unset by event id (1) or
// tick by elapsed milliseconds (2); opcode 3 is dropped without a result.
// out_o returns result words: kind, fired_event, last. Set and unset give one
// word; a tick gives one fired word per reporting slot that expired, in slot
// order, with last on the final one, or a single quiet word.
// One word is taken at a time; in_i.ready is high only while idle.
// Set probes slots up to the first free one; unset and nonzero tick visit
// every slot with a read step and an update step on the single-port slot
// memory; a zero tick goes straight to the final result.
// The final result goes into the output register, so the next command can be
// taken while it waits. A stalled sink holds the output word and pauses the
// slot scan when a second fired word is ready.
// Reset empties every slot and clears the output valid flag; slot contents are
// written on set and need no clearing.
`default_nettype none
module software_timer_pool_core #(
  parameter int unsigned TIMERS = stp_pkg::TimersDefault
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  stp_in_if.sink    in_i,
  stp_out_if.source out_o
);

  stp_pkg::cmd_t cmd;
  stp_pkg::sts_t sts;

  stp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stp_datapath #(
    .TIMERS (TIMERS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_opcode_i        (in_i.opcode),
    .in_event_id_i      (in_i.event_id),
    .in_duration_i      (in_i.duration),
    .in_periodic_i      (in_i.periodic),
    .in_report_enable_i (in_i.report_enable),
    .in_elapsed_i       (in_i.elapsed),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_kind_o         (out_o.kind),
    .out_fired_event_o  (out_o.fired_event),
    .out_last_o         (out_o.last)
  );

endmodule
`default_nettype wire

### rtl/stp_checker.sv
`default_nettype none
`include "software_timer_pool_core_defines.svh"
module stp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  out_kind_i,
  input wire logic [15:0] out_fired_event_i,
  input wire logic        out_last_i
);

  logic in_acc;
  logic out_busy;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_busy = out_valid_i && !out_ready_i;

  `STP_ASSERT_NEXT(a_out_hold, out_busy, out_valid_i && $stable(out_kind_i) && $stable(out_fired_event_i) && $stable(out_last_i))
  `STP_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready_i)
  `STP_ASSERT_NOW(a_single_final, out_valid_i && (out_kind_i != stp_pkg::KindFired), out_last_i && (out_fired_event_i == '0))
  `STP_ASSERT_NOW(a_kind_legal, out_valid_i, out_kind_i <= stp_pkg::KindTickQuiet)

endmodule

bind software_timer_pool_core stp_checker u_stp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_kind_i        (out_o.kind),
  .out_fired_event_i (out_o.fired_event),
  .out_last_i        (out_o.last)
);
`default_nettype wire

### test/software_timer_pool_core_test.sv
typedef struct packed {
  stp_pkg::kind_e kind;
  logic [15:0]    fired_event;
  logic           last;
} timer_word_t;

// Mirror of the slot pool; keeps the words each accepted command must produce.
class timer_expiry_board;
  bit          armed     [stp_pkg::TimersDefault];
  logic [15:0] tag       [stp_pkg::TimersDefault];
  logic [30:0] reload_ms [stp_pkg::TimersDefault];
  int          left_ms   [stp_pkg::TimersDefault];
  bit          periodic  [stp_pkg::TimersDefault];
  bit          reports   [stp_pkg::TimersDefault];
  timer_word_t due_words [$];
  int          failures;

  function int words_due();
    return due_words.size();
  endfunction

  function void note_command(stp_pkg::op_e op, logic [15:0] ev, logic [30:0] dur, logic per,
                             logic rep, logic [30:0] el);
    timer_word_t burst [$];
    bit          placed;
    longint      left;
    placed = 1'b0;
    case (op)
      stp_pkg::OpSet: begin
        for (int i = 0; i < stp_pkg::TimersDefault; i++) begin
          if (!armed[i] && !placed) begin
            armed[i]     = 1'b1;
            tag[i]       = ev;
            reload_ms[i] = dur;
            left_ms[i]   = int'({1'b0, dur});
            periodic[i]  = per;
            reports[i]   = rep;
            placed       = 1'b1;
          end
        end
        due_words.push_back('{kind: placed ? stp_pkg::KindSetDone : stp_pkg::KindSetFull,
                              fired_event: 16'h0, last: 1'b1});
      end
      stp_pkg::OpUnset: begin
        for (int i = 0; i < stp_pkg::TimersDefault; i++) begin
          if (armed[i] && tag[i] == ev) armed[i] = 1'b0;
        end
        due_words.push_back('{kind: stp_pkg::KindUnsetDone, fired_event: 16'h0, last: 1'b1});
      end
      stp_pkg::OpTick: begin
        if (el != '0) begin
          for (int i = 0; i < stp_pkg::TimersDefault; i++) begin
            if (armed[i]) begin
              // remaining time is never negative before a tick, so no clamping is needed
              left = longint'(left_ms[i]) - longint'({1'b0, el});
              left_ms[i] = int'(left);
              if (left <= 0) begin
                if (reports[i] && burst.size() < stp_pkg::MaxResults) begin
                  burst.push_back('{kind: stp_pkg::KindFired, fired_event: tag[i], last: 1'b0});
                end
                if (periodic[i]) left_ms[i] = int'({1'b0, reload_ms[i]});
                else armed[i] = 1'b0;
              end
            end
          end
        end
        if (burst.size() == 0) begin
          due_words.push_back('{kind: stp_pkg::KindTickQuiet, fired_event: 16'h0, last: 1'b1});
        end else begin
          burst[burst.size() - 1].last = 1'b1;
          foreach (burst[i]) due_words.push_back(burst[i]);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_word(logic [2:0] kind, logic [15:0] fired_event, logic last);
    timer_word_t w;
    if (due_words.size() == 0) begin
      $error("unexpected word: kind %0d fired_event %0d last %0d", kind, fired_event, last);
      failures++;
      return;
    end
    w = due_words.pop_front();
    if (kind !== w.kind) begin
      $error("kind: expected %0d, got %0d", w.kind, kind);
      failures++;
    end
    if (fired_event !== w.fired_event) begin
      $error("fired_event: expected %0d, got %0d", w.fired_event, fired_event);
      failures++;
    end
    if (last !== w.last) begin
      $error("last: expected %0d, got %0d", w.last, last);
      failures++;
    end
  endfunction
endclass

module software_timer_pool_core_test;

  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 64;
  localparam int PhaseWords    = 82;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  stp_in_if  in_if ();
  stp_out_if out_if ();

  timer_expiry_board board;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int quiet_cycles  = 0;

  software_timer_pool_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        board.check_word(out_if.kind, out_if.fired_event, out_if.last);
      end
      if (in_if.valid && in_if.ready) begin
        board.note_command(stp_pkg::op_e'(in_if.opcode), in_if.event_id, in_if.duration,
                           in_if.periodic, in_if.report_enable, in_if.elapsed);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : result_sink
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        // long hold-off: the block fills up and drops its input ready
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_command(stp_pkg::op_e op, logic [15:0] ev, logic [30:0] dur, logic per,
                              logic rep, logic [30:0] el);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.event_id      <= ev;
    in_if.duration      <= dur;
    in_if.periodic      <= per;
    in_if.report_enable <= rep;
    in_if.elapsed       <= el;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.words_due() != 0);
  endtask

  task automatic send_random_command();
    int           sel;
    stp_pkg::op_e op;
    logic [15:0]  ev;
    logic [30:0]  dur;
    logic [30:0]  el;
    logic         per;
    logic         rep;
    sel = $urandom_range(99);
    if (sel < 35) op = stp_pkg::OpSet;
    else if (sel < 55) op = stp_pkg::OpUnset;
    else if (sel < 95) op = stp_pkg::OpTick;
    else op = stp_pkg::OpNone;
    per = 1'($urandom_range(1));
    rep = ($urandom_range(3) != 0);
    // periodic slots keep small ids so that unsets can free them again
    if (!per && $urandom_range(3) == 0) ev = 16'($urandom);
    else ev = 16'($urandom_range(15));
    case ($urandom_range(7))
      0: dur = 31'($urandom);
      1: dur = '0;
      default: dur = 31'($urandom_range(40));
    endcase
    case ($urandom_range(7))
      0: el = 31'($urandom);
      1: el = '0;
      default: el = 31'($urandom_range(12));
    endcase
    send_command(op, ev, dur, per, rep, el);
  endtask

  initial begin : stimulus
    board = new();
    in_if.valid         <= 1'b0;
    in_if.opcode        <= stp_pkg::OpNone;
    in_if.event_id      <= '0;
    in_if.duration      <= '0;
    in_if.periodic      <= 1'b0;
    in_if.report_enable <= 1'b0;
    in_if.elapsed       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(stp_pkg::OpUnset, 16'h0000, '0, 1'b0, 1'b0, '0);
    send_command(stp_pkg::OpTick, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, '0);
    send_command(stp_pkg::OpSet, 16'hFFFF, '0, 1'b1, 1'b1, 31'h7FFF_FFFF);
    send_command(stp_pkg::OpSet, 16'h0000, 31'h7FFF_FFFF, 1'b0, 1'b1, '0);
    send_command(stp_pkg::OpSet, 16'h00AA, 31'd3, 1'b0, 1'b0, '0);
    send_command(stp_pkg::OpTick, 16'h0000, '0, 1'b0, 1'b0, 31'd1);
    send_command(stp_pkg::OpTick, 16'h0000, '0, 1'b0, 1'b0, 31'h7FFF_FFFF);
    send_command(stp_pkg::OpNone, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, 31'h7FFF_FFFF);
    // fill the pool; the last set is turned away
    for (int i = 1; i <= 16; i++) begin
      send_command(stp_pkg::OpSet, 16'(i), '0, 1'b0, 1'b1, '0);
    end
    send_command(stp_pkg::OpTick, 16'h0000, '0, 1'b0, 1'b0, 31'd1);
    send_command(stp_pkg::OpUnset, 16'hFFFF, '0, 1'b0, 1'b0, '0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_requests++; end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (PhaseWords) send_random_command();
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
